[sv/uartsd_pkg.sv]
// ----------------------------------------------------------------------------
// uartsd_pkg: shared types and constants of the UART serial datapath
// Request and response payloads, configuration and status structs, command
// codes and the character parity function.
// ----------------------------------------------------------------------------
package uartsd_pkg;

	// Command codes carried in a request
	localparam logic [3:0] CMD_IDLE      = 4'd0;
	localparam logic [3:0] CMD_LOAD      = 4'd1;
	localparam logic [3:0] CMD_TX_START  = 4'd2;
	localparam logic [3:0] CMD_TX_DATA   = 4'd3;
	localparam logic [3:0] CMD_TX_PARITY = 4'd4;
	localparam logic [3:0] CMD_TX_STOP   = 4'd5;
	localparam logic [3:0] CMD_RX_START  = 4'd6;
	localparam logic [3:0] CMD_RX_DATA   = 4'd7;
	localparam logic [3:0] CMD_RX_PARITY = 4'd8;
	localparam logic [3:0] CMD_RX_STOP   = 4'd9;
	localparam logic [3:0] CMD_READ      = 4'd10;
	localparam logic [3:0] CMD_CLR_ERR   = 4'd11;
	localparam logic [3:0] CMD_CLEAR     = 4'd12;

	// Configuration register indexes
	localparam logic [1:0] REG_DATA_BITS     = 2'd0;
	localparam logic [1:0] REG_PARITY_ENABLE = 2'd1;
	localparam logic [1:0] REG_EVEN_PARITY   = 2'd2;

	// Reset values of the configuration registers
	localparam logic [1:0] DATA_BITS_RESET = 2'd3;

	typedef struct packed {
		logic [3:0] command;
		logic       rx_line;
		logic [7:0] load_byte;
	} req_t;

	typedef struct packed {
		logic       tx_line;
		logic       rx_empty;
		logic       rx_full;
		logic       parity_fault;
		logic       framing_fault;
		logic       overrun_fault;
		logic [7:0] read_data;
	} rsp_t;

	typedef struct packed {
		logic [1:0] data_bits_code;
		logic       parity_enable;
		logic       even_parity;
	} cfg_t;

	typedef struct packed {
		logic parity;
		logic framing;
		logic overrun;
	} fault_t;

	// Bit datapath to receive ring
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clr;
		logic [7:0] data;
	} ring_ctl_t;

	// Receive ring to bit datapath and result register
	typedef struct packed {
		logic       full_now;
		logic       empty;
		logic       full;
		logic [7:0] popped;
	} ring_stat_t;

	// Parity bit over the low (code + 5) bits of v
	function automatic logic parity_bit(logic [7:0] v, logic [1:0] code, logic even);
		logic [7:0] mask;
		mask = 8'hFF >> (2'd3 - code);
		return (^(v & mask)) ^ ~even;
	endfunction

endpackage

[sv/uartsd_ring.sv]
// ----------------------------------------------------------------------------
// uartsd_ring: receive ring buffer
// Head/tail pointers, byte memory with registered read at the tail and the
// held popped byte. Holds at most DEPTH-1 bytes.
// ----------------------------------------------------------------------------
module uartsd_ring #(
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uartsd_pkg::ring_ctl_t ctl,
	output uartsd_pkg::ring_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [PW-1:0] ZERO = '0;
	localparam logic [PW-1:0] ONE  = PW'(1);

	logic [PW-1:0] head_q, tail_q, head_d, tail_d;
	logic [PW-1:0] head_nx, head_d_nx;
	logic [7:0]    popped_q, popped_d;
	logic [7:0]    rd_q;
	logic          empty_now, wr_en, rd_en;
	logic [7:0]    mem [DEPTH];

	assign head_nx   = (head_q == LAST) ? ZERO : head_q + ONE;
	assign empty_now = (head_q == tail_q);
	assign wr_en     = ctl.push & ~ctl.clr;
	assign rd_en     = ctl.pop & ~empty_now & ~ctl.clr;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		popped_d = popped_q;
		if (ctl.clr) begin
			head_d   = ZERO;
			tail_d   = ZERO;
			popped_d = 8'd0;
		end else begin
			if (wr_en) begin
				head_d = head_nx;
			end
			if (rd_en) begin
				tail_d   = (tail_q == LAST) ? ZERO : tail_q + ONE;
				popped_d = rd_q;
			end
		end
	end

	assign head_d_nx = (head_d == LAST) ? ZERO : head_d + ONE;

	assign stat.full_now = (head_nx == tail_q);
	assign stat.empty    = (head_d == tail_d);
	assign stat.full     = (head_d_nx == tail_d);
	assign stat.popped   = popped_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= ZERO;
			tail_q   <= ZERO;
			popped_q <= 8'd0;
		end else begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			popped_q <= popped_d;
		end
	end

	// Keep the entry at the new tail ready; forward a write to that entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head_q] <= ctl.data;
		end
		if (wr_en && (head_q == tail_d)) begin
			rd_q <= ctl.data;
		end else begin
			rd_q <= mem[tail_d];
		end
	end

endmodule

[sv/uartsd_bits.sv]
// ----------------------------------------------------------------------------
// uartsd_bits: transmit/receive bit datapath
// Transmit shifter and line level, receive shifter, parity and framing
// checks, sticky fault flags and the push request into the receive ring.
// ----------------------------------------------------------------------------
module uartsd_bits (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  uartsd_pkg::req_t       req,
	input  uartsd_pkg::cfg_t       cfg,
	input  logic                   ring_full,
	output logic                   tx_level_d,
	output uartsd_pkg::fault_t     fault_d,
	output uartsd_pkg::ring_ctl_t  ring_ctl
);

	logic [7:0]         tx_shift_q, tx_shift_d;
	logic [7:0]         tx_held_q, tx_held_d;
	logic               tx_level_q;
	logic [7:0]         rx_shift_q, rx_shift_d;
	uartsd_pkg::fault_t fault_q;
	logic [7:0]         aligned;

	assign aligned = rx_shift_q >> (2'd3 - cfg.data_bits_code);

	always_comb begin
		tx_shift_d    = tx_shift_q;
		tx_held_d     = tx_held_q;
		tx_level_d    = tx_level_q;
		rx_shift_d    = rx_shift_q;
		fault_d       = fault_q;
		ring_ctl.push = 1'b0;
		ring_ctl.pop  = 1'b0;
		ring_ctl.clr  = 1'b0;
		ring_ctl.data = aligned;
		if (fire) begin
			case (req.command)
				uartsd_pkg::CMD_LOAD: begin
					tx_shift_d = req.load_byte;
					tx_held_d  = req.load_byte;
				end
				uartsd_pkg::CMD_TX_START: begin
					tx_level_d = 1'b0;
				end
				uartsd_pkg::CMD_TX_DATA: begin
					tx_level_d = tx_shift_q[0];
					tx_shift_d = {1'b0, tx_shift_q[7:1]};
				end
				uartsd_pkg::CMD_TX_PARITY: begin
					if (cfg.parity_enable) begin
						tx_level_d = uartsd_pkg::parity_bit(tx_held_q,
							cfg.data_bits_code, cfg.even_parity);
					end
				end
				uartsd_pkg::CMD_TX_STOP: begin
					tx_level_d = 1'b1;
				end
				uartsd_pkg::CMD_RX_START: begin
					if (req.rx_line) begin
						fault_d.framing = 1'b1;
					end
				end
				uartsd_pkg::CMD_RX_DATA: begin
					rx_shift_d = {req.rx_line, rx_shift_q[7:1]};
				end
				uartsd_pkg::CMD_RX_PARITY: begin
					if (cfg.parity_enable && (req.rx_line != uartsd_pkg::parity_bit(aligned,
						cfg.data_bits_code, cfg.even_parity))) begin
						fault_d.parity = 1'b1;
					end
				end
				uartsd_pkg::CMD_RX_STOP: begin
					if (!req.rx_line) begin
						fault_d.framing = 1'b1;
					end else if (ring_full) begin
						fault_d.overrun = 1'b1;
					end else if (!fault_q.framing &&
						!(cfg.parity_enable && fault_q.parity)) begin
						ring_ctl.push = 1'b1;
					end
				end
				uartsd_pkg::CMD_READ: begin
					ring_ctl.pop = 1'b1;
				end
				uartsd_pkg::CMD_CLR_ERR: begin
					fault_d = '0;
				end
				uartsd_pkg::CMD_CLEAR: begin
					tx_shift_d   = 8'd0;
					tx_held_d    = 8'd0;
					tx_level_d   = 1'b1;
					rx_shift_d   = 8'd0;
					fault_d      = '0;
					ring_ctl.clr = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_shift_q <= 8'd0;
			tx_held_q  <= 8'd0;
			tx_level_q <= 1'b1;
			rx_shift_q <= 8'd0;
			fault_q    <= '0;
		end else begin
			tx_shift_q <= tx_shift_d;
			tx_held_q  <= tx_held_d;
			tx_level_q <= tx_level_d;
			rx_shift_q <= rx_shift_d;
			fault_q    <= fault_d;
		end
	end

endmodule

[sv/uart_serial_datapath_unit.sv]
// ----------------------------------------------------------------------------
// uart_serial_datapath_unit: UART bit datapath, one sequencer command a request
// Executes transmit, receive, read and clear commands against the line,
// shifter, fault and receive ring state; returns the state after each command.
// ----------------------------------------------------------------------------
//
//  channel   signals                          payload
//  -------   ------------------------------   -----------------------------
//  request   req_valid / req_stall / req_data uartsd_pkg::req_t
//  response  rsp_valid / rsp_stall / rsp_data uartsd_pkg::rsp_t
//  config    cfg_we / cfg_index / cfg_wdata   2-bit data, index 0..2
//
//  One request per clock is sustained while the response side does not stall;
//  a request passes through the input register, then the response register.
//  The single command stage updates all state from the input register, so
//  command k+1 sees exactly what command k left.
//  Reset clears control state and the ring pointers at once; the ring memory
//  itself is never swept.
//  A stalled response holds the command stage; req_stall rises once the input
//  register also holds a request, so an empty input register takes one more.
// ----------------------------------------------------------------------------
module uart_serial_datapath_unit #(
	parameter int RX_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  uartsd_pkg::req_t req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output uartsd_pkg::rsp_t rsp_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [1:0]       cfg_wdata
);

	uartsd_pkg::cfg_t       cfg_q;
	uartsd_pkg::req_t       req_s1;
	logic                   valid_s1;
	logic                   rsp_valid_q;
	uartsd_pkg::rsp_t       rsp_q;
	logic                   fire;
	logic                   tx_level_d;
	uartsd_pkg::fault_t     fault_d;
	uartsd_pkg::ring_ctl_t  ring_ctl;
	uartsd_pkg::ring_stat_t ring_stat;

	// Configuration registers; writes to an unused index drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_bits_code <= uartsd_pkg::DATA_BITS_RESET;
			cfg_q.parity_enable  <= 1'b0;
			cfg_q.even_parity    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				uartsd_pkg::REG_DATA_BITS:     cfg_q.data_bits_code <= cfg_wdata;
				uartsd_pkg::REG_PARITY_ENABLE: cfg_q.parity_enable  <= cfg_wdata[0];
				uartsd_pkg::REG_EVEN_PARITY:   cfg_q.even_parity    <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Execute the held request when the response register is free or drains
	assign fire      = valid_s1 & (~rsp_valid_q | ~rsp_stall);
	// Stall only when the input register holds a request that cannot advance
	assign req_stall = valid_s1 & rsp_valid_q & rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// Capture the request payload only on acceptance
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
	end

	uartsd_bits u_bits (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req        (req_s1),
		.cfg        (cfg_q),
		.ring_full  (ring_stat.full_now),
		.tx_level_d (tx_level_d),
		.fault_d    (fault_d),
		.ring_ctl   (ring_ctl)
	);

	uartsd_ring #(
		.DEPTH (RX_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.stat   (ring_stat)
	);

	// Response valid: set on execute, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Snapshot the state as it stands after the command
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.tx_line       <= tx_level_d;
			rsp_q.rx_empty      <= ring_stat.empty;
			rsp_q.rx_full       <= ring_stat.full;
			rsp_q.parity_fault  <= fault_d.parity;
			rsp_q.framing_fault <= fault_d.framing;
			rsp_q.overrun_fault <= fault_d.overrun;
			rsp_q.read_data     <= ring_stat.popped;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

[tb/tb_uart_serial_datapath_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_serial_datapath_unit: self-checking bench for the UART bit datapath
// Drives sequencer commands through the valid/stall request channel. Traffic
// is mostly well-formed transmit and receive frames, with broken frames and
// noise mixed in. Each request predicts the status it should return, and
// each response is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_uart_serial_datapath_unit;
	import uartsd_pkg::*;

	localparam int         RX_DEPTH      = 16;
	localparam int         HOLD_CYCLES   = 300;  // long receiver hold-off
	localparam int         SETTLE_CYCLES = 6;    // settling margin after the last response
	localparam logic [1:0] REG_SPARE     = 2'd3; // index with no register behind it
	localparam logic [3:0] CMD_UNUSED    = 4'd15; // reserved code, decodes as idle

	// Receive frame defects
	localparam int FLAW_NONE   = 0;
	localparam int FLAW_START  = 1;
	localparam int FLAW_PARITY = 2;
	localparam int FLAW_STOP   = 3;

	// Status predictor: tracks line, shifter, ring and fault state per request
	class uart_status_model;
		logic [1:0] bits_code;
		logic       par_en;
		logic       par_even;
		logic [7:0] tx_shift;
		logic [7:0] tx_held;
		logic       tx_level;
		logic [7:0] rx_shift;
		logic [7:0] ring [RX_DEPTH];
		int         head;
		int         tail;
		logic       flt_par;
		logic       flt_frm;
		logic       flt_ovr;
		logic [7:0] popped;
		rsp_t       status_due [$];
		int         mismatches;

		function new();
			bits_code  = DATA_BITS_RESET;
			par_en     = 1'b0;
			par_even   = 1'b1;
			mismatches = 0;
			clear_state();
		endfunction

		function void clear_state();
			tx_shift = 8'h00;
			tx_held  = 8'h00;
			tx_level = 1'b1;
			rx_shift = 8'h00;
			head     = 0;
			tail     = 0;
			flt_par  = 1'b0;
			flt_frm  = 1'b0;
			flt_ovr  = 1'b0;
			popped   = 8'h00;
		endfunction

		function void set_register(logic [1:0] idx, logic [1:0] val);
			case (idx)
				REG_DATA_BITS:     bits_code = val;
				REG_PARITY_ENABLE: par_en    = val[0];
				REG_EVEN_PARITY:   par_even  = val[0];
				default: ;
			endcase
		endfunction

		function logic char_parity(logic [7:0] v);
			logic ones;
			ones = 1'b0;
			for (int i = 0; i < int'(bits_code) + 5; i++) ones ^= v[i];
			return par_even ? ones : ~ones;
		endfunction

		function int next_slot(int p);
			return (p + 1) % RX_DEPTH;
		endfunction

		function void note_request(req_t r);
			logic [7:0] aligned;
			rsp_t       e;
			aligned = rx_shift >> (3 - bits_code);
			case (r.command)
				CMD_LOAD: begin
					tx_shift = r.load_byte;
					tx_held  = r.load_byte;
				end
				CMD_TX_START: tx_level = 1'b0;
				CMD_TX_DATA: begin
					tx_level = tx_shift[0];
					tx_shift = tx_shift >> 1;
				end
				CMD_TX_PARITY: if (par_en) tx_level = char_parity(tx_held);
				CMD_TX_STOP:   tx_level = 1'b1;
				CMD_RX_START:  if (r.rx_line) flt_frm = 1'b1;
				CMD_RX_DATA:   rx_shift = {r.rx_line, rx_shift[7:1]};
				CMD_RX_PARITY: if (par_en && r.rx_line != char_parity(aligned)) flt_par = 1'b1;
				CMD_RX_STOP: begin
					if (!r.rx_line) flt_frm = 1'b1;
					else if (next_slot(head) == tail) flt_ovr = 1'b1;
					else if (!flt_frm && !(par_en && flt_par)) begin
						ring[head] = aligned;
						head       = next_slot(head);
					end
				end
				CMD_READ: begin
					if (head != tail) begin
						popped = ring[tail];
						tail   = next_slot(tail);
					end
				end
				CMD_CLR_ERR: begin
					flt_par = 1'b0;
					flt_frm = 1'b0;
					flt_ovr = 1'b0;
				end
				CMD_CLEAR: clear_state();
				default: ;
			endcase
			e.tx_line       = tx_level;
			e.rx_empty      = (head == tail);
			e.rx_full       = (next_slot(head) == tail);
			e.parity_fault  = flt_par;
			e.framing_fault = flt_frm;
			e.overrun_fault = flt_ovr;
			e.read_data     = popped;
			status_due.push_back(e);
		endfunction

		task report(string what, logic [7:0] got, logic [7:0] want);
			$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
			mismatches++;
		endtask

		task check_status(rsp_t got);
			rsp_t want;
			if (status_due.size() == 0) begin
				report("response with no request", got.read_data, 8'h00);
			end else begin
				want = status_due.pop_front();
				if (got.tx_line !== want.tx_line)
					report("tx_line", 8'(got.tx_line), 8'(want.tx_line));
				if (got.rx_empty !== want.rx_empty)
					report("rx_empty", 8'(got.rx_empty), 8'(want.rx_empty));
				if (got.rx_full !== want.rx_full)
					report("rx_full", 8'(got.rx_full), 8'(want.rx_full));
				if (got.parity_fault !== want.parity_fault)
					report("parity_fault", 8'(got.parity_fault), 8'(want.parity_fault));
				if (got.framing_fault !== want.framing_fault)
					report("framing_fault", 8'(got.framing_fault), 8'(want.framing_fault));
				if (got.overrun_fault !== want.overrun_fault)
					report("overrun_fault", 8'(got.overrun_fault), 8'(want.overrun_fault));
				if (got.read_data !== want.read_data)
					report("read_data", got.read_data, want.read_data);
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req_data;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_t       rsp_data;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [1:0] cfg_wdata;

	uart_status_model book;
	int               sent_count;
	bit               no_gaps;      // burst stretch: neither side idles
	bit               hold_request; // ask the receiver for one long hold-off

	uart_serial_datapath_unit #(
		.RX_DEPTH(RX_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function int pick_gap();
		return no_gaps ? 0 : $urandom_range(0, 6);
	endfunction

	// Offer one request after a random gap; hold it until the block takes it
	task send_cmd(logic [3:0] cmd, logic line, logic [7:0] lb);
		req_t r;
		int   gap;
		r.command   = cmd;
		r.rx_line   = line;
		r.load_byte = lb;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		book.note_request(r);
		sent_count++;
		@(negedge clk);
	endtask

	// Command whose line and byte fields are don't-care: randomize them
	task send_op(logic [3:0] cmd);
		send_cmd(cmd, 1'($urandom_range(0, 1)), 8'($urandom));
	endtask

	// Transmit one character: load, start, data bits, parity slot (always with parity on, sometimes without), stop
	task tx_frame(logic [7:0] lb);
		send_cmd(CMD_LOAD, 1'($urandom_range(0, 1)), lb);
		send_op(CMD_TX_START);
		for (int i = 0; i < int'(book.bits_code) + 5; i++) send_op(CMD_TX_DATA);
		if (book.par_en || $urandom_range(0, 3) == 0) send_op(CMD_TX_PARITY);
		send_op(CMD_TX_STOP);
	endtask

	// Receive one character, optionally with a bad start, parity or stop bit
	task rx_frame(logic [7:0] ch, int flaw);
		logic par;
		par = book.char_parity(ch);
		send_cmd(CMD_RX_START, flaw == FLAW_START, 8'($urandom));
		for (int i = 0; i < int'(book.bits_code) + 5; i++)
			send_cmd(CMD_RX_DATA, ch[i], 8'($urandom));
		if (book.par_en || $urandom_range(0, 3) == 0)
			send_cmd(CMD_RX_PARITY, par ^ (flaw == FLAW_PARITY), 8'($urandom));
		send_cmd(CMD_RX_STOP, flaw != FLAW_STOP, 8'($urandom));
	endtask

	// Drop valid and hold until every predicted status has come back
	task wait_drained();
		req_valid <= 1'b0;
		while (book.status_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Leaves the write enable high so back-to-back writes need no toggle
	task write_register(logic [1:0] idx, logic [1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		book.set_register(idx, val);
		@(negedge clk);
	endtask

	// Reprogram the character format while the block is idle
	task set_line_format(logic [1:0] code, logic pen, logic peven);
		logic junk_a;
		logic junk_b;
		junk_a = 1'($urandom_range(0, 1));
		junk_b = 1'($urandom_range(0, 1));
		wait_drained();
		write_register(REG_SPARE, 2'($urandom_range(0, 3)));
		write_register(REG_DATA_BITS, code);
		// upper data bit of the 1-bit registers must be masked off
		write_register(REG_PARITY_ENABLE, {junk_a, pen});
		write_register(REG_EVEN_PARITY, {junk_b, peven});
		cfg_we <= 1'b0;
	endtask

	// Random traffic; read_weight steers the ring toward empty or full
	task run_mix(int items, int read_weight);
		int stop_at;
		int pick;
		int sub;
		stop_at = sent_count + items;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 99) < 5) no_gaps = ~no_gaps;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// clear sticky faults now and then so good frames reach the ring
				if ((book.flt_par || book.flt_frm || book.flt_ovr) && $urandom_range(0, 1))
					send_op(CMD_CLR_ERR);
				rx_frame(8'($urandom), FLAW_NONE);
			end else if (pick < 52) begin
				rx_frame(8'($urandom), $urandom_range(FLAW_START, FLAW_STOP));
			end else if (pick < 52 + read_weight) begin
				send_op(CMD_READ);
			end else begin
				sub = $urandom_range(0, 19);
				if (sub < 8) tx_frame(8'($urandom));
				else if (sub < 13) send_op(CMD_CLR_ERR);
				else if (sub == 13) send_op(CMD_CLEAR);
				else send_op(4'($urandom_range(0, 15)));
			end
		end
	endtask

	// Response side: random stalls, one long hold-off on request, check each status
	initial begin : response_side
		int gap;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = pick_gap();
			end
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			book.check_status(rsp_data);
			@(negedge clk);
		end
	end

	initial begin : request_side
		book         = new();
		sent_count   = 0;
		no_gaps      = 1'b0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_data     = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset format (8 bits, no parity)
		send_op(CMD_READ);                   // read with the ring empty
		send_cmd(CMD_LOAD, 1'b0, 8'hFF);
		send_op(CMD_TX_START);
		send_op(CMD_TX_DATA);
		send_op(CMD_TX_PARITY);              // parity off: line holds
		send_op(CMD_TX_STOP);
		send_cmd(CMD_LOAD, 1'b1, 8'h00);
		send_op(CMD_TX_DATA);
		send_cmd(CMD_RX_START, 1'b0, 8'h00);
		for (int i = 0; i < 8; i++) send_cmd(CMD_RX_DATA, 1'b1, 8'hFF);
		send_cmd(CMD_RX_PARITY, 1'b0, 8'h00); // parity off: no fault
		send_cmd(CMD_RX_STOP, 1'b1, 8'h00);
		send_op(CMD_READ);
		send_cmd(CMD_RX_START, 1'b1, 8'h00);  // bad start bit
		send_cmd(CMD_RX_STOP, 1'b0, 8'h00);   // bad stop bit
		send_op(CMD_CLR_ERR);
		send_op(CMD_IDLE);
		send_op(CMD_UNUSED);                  // unused code acts as idle
		send_op(CMD_CLEAR);

		// Random phases across formats; hold off the receiver early in the first
		set_line_format(2'd0, 1'b1, 1'b0);
		hold_request = 1'b1;
		run_mix(330, 20);
		set_line_format(2'd3, 1'b1, 1'b1);
		run_mix(330, 3);                      // push-heavy: fill and overrun
		set_line_format(2'd1, 1'b0, 1'b0);
		run_mix(330, 40);                     // read-heavy: drain, empty reads
		set_line_format(2'd2, 1'b1, 1'b1);
		run_mix(330, 20);
		set_line_format(2'd3, 1'b0, 1'b1);
		run_mix(330, 10);
		set_line_format(2'd0, 1'b0, 1'b1);
		run_mix(330, 15);

		wait_drained();
		if (book.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
sv/uartsd_pkg.sv
sv/uartsd_ring.sv
sv/uartsd_bits.sv
sv/uart_serial_datapath_unit.sv
tb/tb_uart_serial_datapath_unit.sv
